// ----- rtl/fdl_pkg.sv -----
// fdl_pkg: shared constants and types for the fractional feedback delay line
// register indexes, configuration widths and output queue sizing
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package fdl_pkg;

	localparam int DELAY_W     = 18;
	localparam int FRAC_W      = 16;
	localparam int GAIN_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int DELAY_RESET = 48000;

	// fixed-point alignment: gain is Q2.14, fraction is Q0.16
	localparam int FB_SHIFT = 14;
	localparam int BL_SHIFT = 16;

	// output queue
	localparam int OFIFO_AW    = 2;
	localparam int OFIFO_DEPTH = 1 << OFIFO_AW;

	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [DELAY_W-1:0]       cfg_data_t;
	typedef logic [FRAC_W-1:0]        frac_t;
	typedef logic signed [GAIN_W-1:0] gain_t;

	localparam cfg_idx_t REG_DELAY_SAMPLES  = 2'd0;
	localparam cfg_idx_t REG_DELAY_FRACTION = 2'd1;
	localparam cfg_idx_t REG_FEEDBACK_GAIN  = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/fdl_ram.sv -----
// fdl_ram: sample store, one write port and one read port, registered read data
// read during write at the same address returns the old entry
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module fdl_ram #(
	parameter int DEPTH = 262144,
	parameter int WIDTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/fdl_mod.sv -----
// fdl_mod: reduces a sum modulo the store depth by reciprocal multiplication
// quotient estimate, remainder, one correcting subtract, one stage each
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module fdl_mod #(
	parameter int DEPTH = 262144,
	parameter int SW    = 19
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [SW-1:0]            value,
	output logic                          busy,
	output logic                          done,
	output logic      [$clog2(DEPTH)-1:0] result
);

	localparam int PW  = $clog2(DEPTH);
	localparam int QW  = SW - PW + 1;
	localparam int PRW = 2 * SW + 1;
	// reciprocal scaled by 2^(SW+PW); the quotient estimate is low by at most one
	localparam longint        RECIP   = (longint'(1) << (SW + PW)) / longint'(DEPTH);
	localparam logic [SW:0]   RECIP_C = (SW + 1)'(RECIP);
	localparam logic [SW-1:0] DEPTH_C = SW'(DEPTH);
	localparam logic [PW:0]   DEPTH_R = (PW + 1)'(DEPTH);

	logic [SW-1:0]  val_s1, val_s2;
	logic [PRW-1:0] prod_s2;
	logic [QW-1:0]  quot_c;
	logic [SW-1:0]  qd_c;
	logic [PW:0]    rem_s3;
	logic [PW-1:0]  res_q;
	logic           vld_s1, vld_s2, vld_s3, done_q;

	assign quot_c = prod_s2[PRW-1:SW+PW];
	assign qd_c   = SW'(quot_c) * DEPTH_C;

	always_ff @(posedge clk) begin
		if (start) begin
			val_s1 <= value;
		end
		if (vld_s1) begin
			val_s2  <= val_s1;
			prod_s2 <= PRW'(val_s1) * PRW'(RECIP_C);
		end
		if (vld_s2) begin
			rem_s3 <= (PW + 1)'(val_s2 - qd_c);
		end
		if (vld_s3) begin
			res_q <= (rem_s3 >= DEPTH_R) ? PW'(rem_s3 - DEPTH_R) : rem_s3[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	assign busy   = vld_s1 | vld_s2 | vld_s3 | done_q;
	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

// ----- rtl/fdl_ofifo.sv -----
// fdl_ofifo: small result queue in front of the master stream side
// depends on fdl_pkg for the queue depth
`timescale 1ns / 1ps
`default_nettype none
module fdl_ofifo
	import fdl_pkg::*;
#(
	parameter int WIDTH = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0]    buf_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0] wptr_q;
	logic [OFIFO_AW-1:0] rptr_q;
	logic [OFIFO_AW:0]   cnt_q;
	logic                pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = buf_q[rptr_q];
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/fractional_feedback_delay_line_core.sv -----
// fractional_feedback_delay_line_core: echo delay line with linear fractional
// interpolation and saturating feedback, state held in one sample store
// depends on fdl_pkg, fdl_ram, fdl_mod, fdl_ofifo
//
//   channel   dir  width            accepted when          contents
//   s_*       in   bytes(SAMPLE)    s_tvalid & s_tready    in_sample (low bits)
//   m_*       out  bytes(SAMPLE)    m_tvalid & m_tready    out_sample (low bits)
//   cfg_*     in   2 + 18           cfg_wen                register index, value
//
// a sample request uses both store entries (read position and the one after), which come through
// the single read port of the store, one per cycle; s_tready stays low while the second is read
// m_tvalid rises once stage 3 pushes the result; four results may queue at the output
// after reset the store is swept to zero, with s_tready low until the sweep is done
// writing delay_samples holds s_tready low while the new write
// position is reduced modulo the depth
// the arithmetic pipeline never stalls; s_tready only admits a request with queue room
`timescale 1ns / 1ps
`default_nettype none
module fractional_feedback_delay_line_core
	import fdl_pkg::*;
#(
	parameter int STORE_DEPTH = 262144,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration write port
	input  wire logic                                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]                  cfg_addr,
	input  wire logic [DELAY_W-1:0]                    cfg_wdata,
	// input samples
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,  // in_sample
	// delayed samples
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic      [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata   // out_sample
);

	localparam int SB = SAMPLE_BITS;
	localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int PW = $clog2(STORE_DEPTH);
	localparam int SW = ((PW > DELAY_W) ? PW : DELAY_W) + 1;
	localparam logic [PW-1:0] LAST_ADDR = PW'(STORE_DEPTH - 1);
	localparam logic [PW-1:0] WR_RESET  = PW'(DELAY_RESET % STORE_DEPTH);
	localparam int FB_RND = 1 << (FB_SHIFT - 1);
	localparam int BL_RND = 1 << (BL_SHIFT - 1);

	// configuration
	frac_t frac_q;
	gain_t gain_q;

	// positions and sweep
	logic [PW-1:0] rd_q, wr_q, rd_inc, wr_inc;
	logic          clr_busy_q;
	logic [PW-1:0] clr_addr_q;

	// delay reduction
	logic          mod_start, mod_busy, mod_done;
	logic [SW-1:0] mod_value;
	logic [PW-1:0] mod_result;

	// handshake bookkeeping
	logic              accept, deliver;
	logic [OFIFO_AW:0] occ_q;

	// store ports
	logic          ram_we;
	logic [PW-1:0] ram_waddr;
	logic [SB-1:0] ram_wdata;
	logic [SB-1:0] ram_rdata;

	// pending feedback write, also the forwarding source
	logic          wpend_q, fvld_q;
	logic [PW-1:0] waddr_q;
	logic [SB-1:0] wval_q;

	// stage 1: first entry read in flight
	logic                 vld_s1;
	logic signed [SB-1:0] x_s1;
	logic [PW-1:0]        rd_s1, wr_s1;

	// stage 2: second entry read in flight
	logic                   vld_s2;
	logic signed [SB-1:0]   x_s2, a_s2;
	logic signed [SB+15:0]  fprod_s2;
	logic [PW-1:0]          rdn_s2, wr_s2;

	// stage 3: weighted products
	logic                   vld_s3;
	logic signed [SB+17:0]  pa_s3;
	logic signed [SB+16:0]  pb_s3;

	// combinational datapath
	logic signed [SB-1:0]   a_c, b_c;
	logic signed [SB+15:0]  fprod_c, fsum_c;
	logic signed [SB+1:0]   fed_c;
	logic signed [SB+2:0]   tot_c;
	logic [SB-1:0]          wval_c;
	logic [FRAC_W:0]        inv_w;
	logic signed [SB+17:0]  pa_c;
	logic signed [SB+16:0]  pb_c;
	logic signed [SB+18:0]  bsum_c;
	logic [SB-1:0]          blend_c;
	logic [SB-1:0]          fifo_data;

	// ---------------------------------------------------------------- handshake
	assign s_tready = !clr_busy_q && !mod_busy && !vld_s1 &&
	                  (occ_q < (OFIFO_AW + 1)'(OFIFO_DEPTH));
	assign accept   = s_tvalid & s_tready;
	assign deliver  = m_tvalid & m_tready;

	// requests accepted and not yet delivered; bounds what the pipeline can push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (accept && !deliver) begin
			occ_q <= occ_q + 1'b1;
		end else if (deliver && !accept) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	// ---------------------------------------------------------------- configuration
	assign mod_start = cfg_wen && (cfg_addr == REG_DELAY_SAMPLES);
	assign mod_value = SW'(rd_q) + SW'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= '0;
			gain_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_DELAY_FRACTION: frac_q <= cfg_wdata[FRAC_W-1:0];
				REG_FEEDBACK_GAIN:  gain_q <= $signed(cfg_wdata[GAIN_W-1:0]);
				default: ;
			endcase
		end
	end

	// write position = (read position + delay) mod depth, by reciprocal multiply
	fdl_mod #(
		.DEPTH (STORE_DEPTH),
		.SW    (SW)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (mod_value),
		.busy   (mod_busy),
		.done   (mod_done),
		.result (mod_result)
	);

	// ---------------------------------------------------------------- positions
	assign rd_inc = (rd_q == LAST_ADDR) ? '0 : rd_q + 1'b1;
	assign wr_inc = (wr_q == LAST_ADDR) ? '0 : wr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= WR_RESET;
		end else if (mod_done) begin
			wr_q <= mod_result;
		end else if (accept) begin
			rd_q <= rd_inc;
			wr_q <= wr_inc;
		end
	end

	// zero sweep of the store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- store
	// the read port follows rd_q: at accept it is the first entry, in the cycle after
	// rd_q has advanced and names the second entry
	assign ram_we    = clr_busy_q | wpend_q;
	assign ram_waddr = clr_busy_q ? clr_addr_q : waddr_q;
	assign ram_wdata = clr_busy_q ? '0 : wval_q;

	fdl_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (SB)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept | vld_s1),
		.raddr (rd_q),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1  <= $signed(s_tdata[SB-1:0]);
			rd_s1 <= rd_q;
			wr_s1 <= wr_q;
		end
	end

	// the previous sample's feedback write may not have landed yet: forward it
	assign a_c     = (fvld_q && waddr_q == rd_s1) ? $signed(wval_q) : $signed(ram_rdata);
	assign fprod_c = a_c * gain_q;

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			x_s2     <= x_s1;
			a_s2     <= a_c;
			fprod_s2 <= fprod_c;
			rdn_s2   <= rd_q;
			wr_s2    <= wr_s1;
		end
	end

	// same forwarding for the second entry; its read shared an edge with that write
	assign b_c   = (fvld_q && waddr_q == rdn_s2) ? $signed(wval_q) : $signed(ram_rdata);
	assign inv_w = {1'b1, {FRAC_W{1'b0}}} - {1'b0, frac_q};
	assign pa_c  = a_s2 * $signed({1'b0, inv_w});
	assign pb_c  = b_c * $signed({1'b0, frac_q});

	// feedback: round half up to Q1.23, add the input, clip to full scale
	assign fsum_c = fprod_s2 + $signed((SB + 16)'(FB_RND));
	assign fed_c  = fsum_c[SB+15:FB_SHIFT];
	assign tot_c  = {fed_c[SB+1], fed_c} + {{3{x_s2[SB-1]}}, x_s2};

	always_comb begin
		if ((&tot_c[SB+2:SB-1]) || !(|tot_c[SB+2:SB-1])) begin
			wval_c = tot_c[SB-1:0];
		end else if (tot_c[SB+2]) begin
			wval_c = {1'b1, {(SB-1){1'b0}}};
		end else begin
			wval_c = {1'b0, {(SB-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpend_q <= 1'b0;
			fvld_q  <= 1'b0;
		end else begin
			wpend_q <= vld_s2;
			if (vld_s2) begin
				fvld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			wval_q  <= wval_c;
			waddr_q <= wr_s2;
		end
	end

	// ---------------------------------------------------------------- stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			pa_s3 <= pa_c;
			pb_s3 <= pb_c;
		end
	end

	// blend lies between the two entries, so the narrow slice never overflows
	assign bsum_c  = {pa_s3[SB+17], pa_s3} + {{2{pb_s3[SB+16]}}, pb_s3} +
	                 $signed((SB + 19)'(BL_RND));
	assign blend_c = bsum_c[SB+BL_SHIFT-1:BL_SHIFT];

	// ---------------------------------------------------------------- output
	fdl_ofifo #(
		.WIDTH (SB)
	) u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s3),
		.push_data (blend_c),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (fifo_data)
	);

	assign m_tdata = DW'(fifo_data);

endmodule
`default_nettype wire
